// ===== hdl/rapq_pkg.sv =====
`default_nettype none

package rapq_pkg;

    // Request opcodes as carried in the low bits of s_tdata
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Program counter of the microcode sequencer
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Microcode step addresses
    localparam pc_t STEP_IDLE       = 4'd0;
    localparam pc_t STEP_ADD_A_INIT = 4'd1;
    localparam pc_t STEP_ADD_A_RD   = 4'd2;
    localparam pc_t STEP_ADD_A_WR   = 4'd3;
    localparam pc_t STEP_ADD_B_INIT = 4'd4;
    localparam pc_t STEP_ADD_B_RD   = 4'd5;
    localparam pc_t STEP_ADD_B_WR   = 4'd6;
    localparam pc_t STEP_QRY_INIT   = 4'd7;
    localparam pc_t STEP_QRY_RD     = 4'd8;
    localparam pc_t STEP_QRY_ACC    = 4'd9;
    localparam pc_t STEP_QRY_OUT    = 4'd10;
    localparam pc_t STEP_CLR_INIT   = 4'd11;
    localparam pc_t STEP_CLR_LOOP   = 4'd12;

    // Jump condition tested by a step
    typedef enum logic [2:0] {
        C_TRUE,
        C_IN_VALID,
        C_OUT_FREE,
        C_WALK_DONE,
        C_SWEEP_LAST
    } cond_t;

    // Where to go when the condition fails
    typedef enum logic {
        ELSE_NEXT,
        ELSE_STAY
    } else_t;

    // Position / sweep address register operation
    typedef enum logic [2:0] {
        P_HOLD,
        P_LOAD_LO,
        P_LOAD_HI1,
        P_LOAD_QRY,
        P_UP,
        P_DOWN,
        P_ZERO,
        P_INC
    } pos_op_t;

    // Walk operand register operation
    typedef enum logic [1:0] {
        V_HOLD,
        V_LOAD,
        V_NEG
    } val_op_t;

    // Query accumulator operation
    typedef enum logic [1:0] {
        A_HOLD,
        A_CLEAR,
        A_ADD
    } acc_op_t;

    // Tree store write operation
    typedef enum logic [1:0] {
        W_NONE,
        W_SUM,
        W_ZERO
    } wr_op_t;

    // One control word
    typedef struct packed {
        cond_t   cond;
        logic    dispatch;
        else_t   on_false;
        pc_t     target;
        logic    accept;
        pos_op_t pos_op;
        val_op_t val_op;
        acc_op_t acc_op;
        logic    rd_en;
        wr_op_t  wr_op;
        logic    out_load;
    } uop_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic walk_done;
        logic sweep_last;
        logic out_free;
    } status_t;

    // Control store
    function automatic uop_t rapq_rom(input pc_t pc);
        uop_t u;
        u.cond     = C_TRUE;
        u.dispatch = 1'b0;
        u.on_false = ELSE_NEXT;
        u.target   = STEP_IDLE;
        u.accept   = 1'b0;
        u.pos_op   = P_HOLD;
        u.val_op   = V_HOLD;
        u.acc_op   = A_HOLD;
        u.rd_en    = 1'b0;
        u.wr_op    = W_NONE;
        u.out_load = 1'b0;
        case (pc)
            STEP_IDLE: begin
                u.cond     = C_IN_VALID;
                u.dispatch = 1'b1;
                u.on_false = ELSE_STAY;
                u.accept   = 1'b1;
            end
            // add at left, walking up
            STEP_ADD_A_INIT: begin
                u.target = STEP_ADD_A_RD;
                u.pos_op = P_LOAD_LO;
                u.val_op = V_LOAD;
            end
            STEP_ADD_A_RD: begin
                u.cond   = C_WALK_DONE;
                u.target = STEP_ADD_B_INIT;
                u.rd_en  = 1'b1;
            end
            STEP_ADD_A_WR: begin
                u.target = STEP_ADD_A_RD;
                u.wr_op  = W_SUM;
                u.pos_op = P_UP;
            end
            // subtract at right+1, walking up
            STEP_ADD_B_INIT: begin
                u.target = STEP_ADD_B_RD;
                u.pos_op = P_LOAD_HI1;
                u.val_op = V_NEG;
            end
            STEP_ADD_B_RD: begin
                u.cond   = C_WALK_DONE;
                u.target = STEP_IDLE;
                u.rd_en  = 1'b1;
            end
            STEP_ADD_B_WR: begin
                u.target = STEP_ADD_B_RD;
                u.wr_op  = W_SUM;
                u.pos_op = P_UP;
            end
            // prefix sum, walking down
            STEP_QRY_INIT: begin
                u.target = STEP_QRY_RD;
                u.pos_op = P_LOAD_QRY;
                u.acc_op = A_CLEAR;
            end
            STEP_QRY_RD: begin
                u.cond   = C_WALK_DONE;
                u.target = STEP_QRY_OUT;
                u.rd_en  = 1'b1;
            end
            STEP_QRY_ACC: begin
                u.target = STEP_QRY_RD;
                u.acc_op = A_ADD;
                u.pos_op = P_DOWN;
            end
            STEP_QRY_OUT: begin
                u.cond     = C_OUT_FREE;
                u.on_false = ELSE_STAY;
                u.target   = STEP_IDLE;
                u.out_load = 1'b1;
            end
            // zero sweep over the store
            STEP_CLR_INIT: begin
                u.target = STEP_CLR_LOOP;
                u.pos_op = P_ZERO;
            end
            STEP_CLR_LOOP: begin
                u.cond     = C_SWEEP_LAST;
                u.on_false = ELSE_STAY;
                u.target   = STEP_IDLE;
                u.wr_op    = W_ZERO;
                u.pos_op   = P_INC;
            end
            default: begin
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rapq_ram.sv =====
`default_nettype none

module rapq_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rapq_useq.sv =====
`default_nettype none

module rapq_useq
    import rapq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid_i,
    input  wire logic [1:0] opcode_i,
    input  wire status_t    status_i,
    output uop_t            uop_o,
    output pc_t             pc_o
);

    pc_t   pc_reg;
    pc_t   pc_next;
    uop_t  uop;
    logic  cond_true;
    pc_t   dispatch_pc;

    assign uop   = rapq_rom(pc_reg);
    assign uop_o = uop;
    assign pc_o  = pc_reg;

    // condition select
    always_comb begin
        case (uop.cond)
            C_TRUE:       cond_true = 1'b1;
            C_IN_VALID:   cond_true = in_valid_i;
            C_OUT_FREE:   cond_true = status_i.out_free;
            C_WALK_DONE:  cond_true = status_i.walk_done;
            C_SWEEP_LAST: cond_true = status_i.sweep_last;
            default:      cond_true = 1'b0;
        endcase
    end

    // opcode jump table
    always_comb begin
        case (opcode_t'(opcode_i))
            OP_ADD:   dispatch_pc = STEP_ADD_A_INIT;
            OP_QUERY: dispatch_pc = STEP_QRY_INIT;
            OP_CLEAR: dispatch_pc = STEP_CLR_INIT;
            default:  dispatch_pc = STEP_IDLE;
        endcase
    end

    // next step
    always_comb begin
        if (cond_true && uop.dispatch) begin
            pc_next = dispatch_pc;
        end else if (cond_true) begin
            pc_next = uop.target;
        end else if (uop.on_false == ELSE_STAY) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    // reset starts the zero sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_CLR_INIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rapq_dpath.sv =====
`default_nettype none

module rapq_dpath
    import rapq_pkg::*;
#(
    parameter int SIZE = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire uop_t        uop_i,
    input  wire logic        req_load_i,
    input  wire logic [10:0] left_index_i,
    input  wire logic [10:0] right_index_i,
    input  wire logic [31:0] add_value_i,
    input  wire logic        m_tready_i,
    output status_t          status_o,
    output logic             m_tvalid_o,
    output logic [63:0]      m_tdata_o
);

    localparam int AW = $clog2(SIZE);
    // wide enough for right+1 and for an upward step past SIZE
    localparam int PW = ($clog2(SIZE) + 2 > 12) ? $clog2(SIZE) + 2 : 12;
    localparam logic [PW-1:0] SIZE_P = PW'(SIZE);

    logic [10:0]   lo_reg;
    logic [10:0]   hi_reg;
    logic [31:0]   v_reg;
    logic [PW-1:0] pos_reg,  pos_next;
    logic [63:0]   val_reg,  val_next;
    logic [63:0]   acc_reg,  acc_next;
    logic [63:0]   out_reg,  out_next;
    logic          m_tvalid_reg, m_tvalid_next;

    logic [PW-1:0] low_bit;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] lo_ext;
    logic          out_free;
    logic          out_fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [63:0]   rd_data;

    assign low_bit  = pos_reg & (~pos_reg + PW'(1));
    assign pos_m1   = pos_reg - PW'(1);
    assign lo_ext   = PW'(lo_reg);
    assign out_free = !m_tvalid_reg || m_tready_i;
    assign out_fire = uop_i.out_load && out_free;

    assign status_o.walk_done  = (pos_reg == '0) || (pos_reg > SIZE_P);
    assign status_o.sweep_last = (pos_reg == SIZE_P - PW'(1));
    assign status_o.out_free   = out_free;

    // request capture
    always_ff @(posedge aclk) begin
        if (req_load_i) begin
            lo_reg <= left_index_i;
            hi_reg <= right_index_i;
            v_reg  <= add_value_i;
        end
    end

    // position / sweep address
    always_comb begin
        case (uop_i.pos_op)
            P_HOLD:     pos_next = pos_reg;
            P_LOAD_LO:  pos_next = lo_ext;
            P_LOAD_HI1: pos_next = PW'(hi_reg) + PW'(1);
            P_LOAD_QRY: pos_next = (lo_ext > SIZE_P) ? SIZE_P : lo_ext;
            P_UP:       pos_next = pos_reg + low_bit;
            P_DOWN:     pos_next = pos_reg - low_bit;
            P_ZERO:     pos_next = '0;
            P_INC:      pos_next = pos_reg + PW'(1);
            default:    pos_next = pos_reg;
        endcase
    end

    // walk operand: sign-extended value, then its negation
    always_comb begin
        case (uop_i.val_op)
            V_LOAD:  val_next = {{32{v_reg[31]}}, v_reg};
            V_NEG:   val_next = 64'd0 - val_reg;
            default: val_next = val_reg;
        endcase
    end

    // query accumulator
    always_comb begin
        case (uop_i.acc_op)
            A_CLEAR: acc_next = '0;
            A_ADD:   acc_next = acc_reg + rd_data;
            default: acc_next = acc_reg;
        endcase
    end

    // store write port
    always_comb begin
        case (uop_i.wr_op)
            W_SUM: begin
                wr_en   = 1'b1;
                wr_addr = pos_m1[AW-1:0];
                wr_data = rd_data + val_reg;
            end
            W_ZERO: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = '0;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = pos_m1[AW-1:0];
                wr_data = '0;
            end
        endcase
    end

    // result register
    always_comb begin
        out_next      = out_fire ? acc_reg : out_reg;
        m_tvalid_next = out_fire ? 1'b1 : (m_tready_i ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid_o = m_tvalid_reg;
    assign m_tdata_o  = out_reg;

    rapq_ram #(
        .WIDTH (64),
        .DEPTH (SIZE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (uop_i.rd_en),
        .rd_addr (pos_m1[AW-1:0]),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== hdl/range_add_point_query_tree.sv =====
// Range-add / point-query tree over positions 1..SIZE of signed 64-bit values.
// Requests come in on the s_ channel, one at a time: opcode 0 adds add_value
// over left_index..right_index, opcode 1 returns the value at left_index,
// opcode 2 zeroes every position, opcode 3 does nothing. Only queries return
// a result, on the m_ channel; sums wrap modulo 2^64.
// Timing is set by the microcode sequencer stepping the store (one write port,
// one registered read port): each tree node takes a registered read step, then
// a write or accumulate step. s_tready is high only while the sequencer waits
// for the next request.
// After reset the store is swept to zero, with s_tready low.
// The result sits in an output register: a stalled receiver does not stop the
// next request from being accepted and worked on; only a second query result
// waits in its final step until the output register is free.
`default_nettype none

module range_add_point_query_tree
    import rapq_pkg::*;
#(
    parameter int SIZE = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // {add_value[55:24], right_index[23:13], left_index[12:2], opcode[1:0]}
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // {point_value[63:0]}
    output logic      [63:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    uop_t    uop;
    pc_t     pc;
    status_t status;
    logic    s_accept;

    assign s_tready = uop.accept;
    assign s_accept = s_tvalid && s_tready;

    rapq_useq u_useq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_tvalid),
        .opcode_i   (s_tdata[1:0]),
        .status_i   (status),
        .uop_o      (uop),
        .pc_o       (pc)
    );

    rapq_dpath #(
        .SIZE (SIZE)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .uop_i         (uop),
        .req_load_i    (s_accept),
        .left_index_i  (s_tdata[12:2]),
        .right_index_i (s_tdata[23:13]),
        .add_value_i   (s_tdata[55:24]),
        .m_tready_i    (m_tready),
        .status_o      (status),
        .m_tvalid_o    (m_tvalid),
        .m_tdata_o     (m_tdata)
    );

    // a result appears only out of the query output step
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pc == STEP_QRY_OUT))
        else $error("result raised outside the query output step");

    // leaving the query output step always leaves a result pending
    a_query_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(pc == STEP_QRY_OUT) && pc == STEP_IDLE) |-> m_tvalid)
        else $error("query finished without a result");

    // the store is never written while a new request can be taken
    a_no_write_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (uop.wr_op != W_NONE) |-> !s_tready)
        else $error("store write while accepting requests");

endmodule

`default_nettype wire
